// ----- src/tbdr_pkg.sv -----
// Shared widths, types and the per-lane weight product for the ternary dot-row block.
package tbdr_pkg;

	localparam int unsigned LANES      = 4;
	localparam int unsigned CODE_W     = 2;
	localparam int unsigned ACT_W      = 8;
	localparam int unsigned SCALE_W    = 16;
	localparam int unsigned LANE_PROD_W = ACT_W + 1;
	localparam int unsigned LANE_SUM_W = LANE_PROD_W + 2;
	localparam int unsigned BLK_W      = 17;
	localparam int unsigned PROD_W     = BLK_W + SCALE_W;
	localparam int unsigned ROW_W      = 42;

	localparam logic signed [ROW_W-1:0] ROW_MAX = {1'b0, {(ROW_W-1){1'b1}}};
	localparam logic signed [ROW_W-1:0] ROW_MIN = {1'b1, {(ROW_W-1){1'b0}}};

	// The weight of a code is the code minus one.
	typedef enum logic [CODE_W-1:0] {
		CODE_NEG  = 2'd0,
		CODE_ZERO = 2'd1,
		CODE_POS  = 2'd2,
		CODE_TWO  = 2'd3
	} weight_code_t;

	typedef logic [LANES-1:0][ACT_W-1:0] act_vec_t;

	// Product of one activation with the weight of its code: a sign flip, zero,
	// a pass or a doubling.
	function automatic logic signed [LANE_PROD_W-1:0] lane_product(
		input logic [CODE_W-1:0] code,
		input logic [ACT_W-1:0]  act
	);
		logic signed [LANE_PROD_W-1:0] ext;
		logic signed [LANE_PROD_W-1:0] res;
		ext = {act[ACT_W-1], act};
		unique case (weight_code_t'(code))
			CODE_NEG:  res = -ext;
			CODE_ZERO: res = '0;
			CODE_POS:  res = ext;
			CODE_TWO:  res = {act, 1'b0};
		endcase
		return res;
	endfunction

endpackage

// ----- src/tbdr_lane_sum.sv -----
// Sum of the four weighted activations carried by one request.
module tbdr_lane_sum (
	input  logic [7:0]                                   codes,
	input  tbdr_pkg::act_vec_t                           acts,
	output logic signed [tbdr_pkg::LANE_SUM_W-1:0]       sum
);
	import tbdr_pkg::*;

	// Add the lane products, each sign-extended to the sum width.
	always_comb begin
		logic signed [LANE_SUM_W-1:0] acc;
		acc = '0;
		for (int l = 0; l < LANES; l++) begin
			acc = acc + LANE_SUM_W'(lane_product(codes[CODE_W*l +: CODE_W], acts[l]));
		end
		sum = acc;
	end

endmodule

// ----- src/ternary_block_dot_row.sv -----
// Top level of the ternary-weight int8 dot product over one matrix row.
//
// Channel  | Handshake            | Payload
// ---------+----------------------+--------------------------------------------------
// input    | in_valid / in_ready  | code_byte, act_0..act_3, block_scale,
//          |                      | block_end, row_end
// result   | out_valid/out_ready  | row_value, saturated (one per row)
//
// One request is taken every cycle while the pipe is not held. A row result is
// presented in an output register, reached through the input, block and scale registers.
// The pipeline is an input register, a block accumulate stage, the block scale
// multiply and the saturating row accumulate; a stage moves when the next is free.
// Only a row-ending request waiting on a full output register holds the pipe.
// Reset clears all valid flags and the block and row totals.
module ternary_block_dot_row (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic [7:0]                              code_byte,
	input  logic signed [tbdr_pkg::ACT_W-1:0]       act_0,
	input  logic signed [tbdr_pkg::ACT_W-1:0]       act_1,
	input  logic signed [tbdr_pkg::ACT_W-1:0]       act_2,
	input  logic signed [tbdr_pkg::ACT_W-1:0]       act_3,
	input  logic signed [tbdr_pkg::SCALE_W-1:0]     block_scale,
	input  logic                                    block_end,
	input  logic                                    row_end,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic signed [tbdr_pkg::ROW_W-1:0]       row_value,
	output logic                                    saturated
);
	import tbdr_pkg::*;

	// Stage 1: registered request.
	logic                          valid_s1;
	logic [7:0]                    codes_s1;
	act_vec_t                      acts_s1;
	logic signed [SCALE_W-1:0]     scale_s1;
	logic                          close_s1;
	logic                          row_end_s1;

	// Stage 2: closed block total awaiting its scale.
	logic                          valid_s2;
	logic signed [BLK_W-1:0]       blk_s2;
	logic signed [SCALE_W-1:0]     scale_s2;
	logic                          row_end_s2;

	// Stage 3: scaled block value.
	logic                          valid_s3;
	logic signed [PROD_W-1:0]      prod_s3;
	logic                          row_end_s3;

	logic signed [BLK_W-1:0]       block_q;
	logic signed [ROW_W-1:0]       row_q;
	logic                          clip_q;

	logic                          out_valid_q;
	logic signed [ROW_W-1:0]       row_value_q;
	logic                          saturated_q;

	logic                          ready1, ready2, ready3;
	logic                          accept, adv1, adv3;
	logic signed [LANE_SUM_W-1:0]  lane_sum;
	logic signed [BLK_W-1:0]       block_next;
	logic signed [PROD_W-1:0]      mul;
	logic signed [ROW_W:0]         row_sum;
	logic signed [ROW_W-1:0]       row_next;
	logic                          row_ovf;

	// Backpressure chain: only a row result facing a full output register stalls.
	assign ready3   = !row_end_s3 || !out_valid_q || out_ready;
	assign ready2   = !valid_s3 || ready3;
	assign ready1   = !valid_s2 || ready2;
	assign in_ready = !valid_s1 || ready1;
	assign accept   = in_valid && in_ready;
	assign adv1     = valid_s1 && ready1;
	assign adv3     = valid_s3 && ready3;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			codes_s1   <= code_byte;
			acts_s1    <= {act_3, act_2, act_1, act_0};
			scale_s1   <= block_scale;
			close_s1   <= block_end || row_end;
			row_end_s1 <= row_end;
		end
	end

	tbdr_lane_sum u_lane_sum (
		.codes (codes_s1),
		.acts  (acts_s1),
		.sum   (lane_sum)
	);

	// Block accumulate, wrapping at the block total width.
	assign block_next = block_q + BLK_W'(lane_sum);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_q <= '0;
		end else if (adv1) begin
			block_q <= close_s1 ? '0 : block_next;
		end
	end

	// Only block-closing requests continue past stage 1.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready1) begin
			valid_s2 <= adv1 && close_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && close_s1) begin
			blk_s2     <= block_next;
			scale_s2   <= scale_s1;
			row_end_s2 <= row_end_s1;
		end
	end

	// Block scale multiply.
	assign mul = PROD_W'(blk_s2) * PROD_W'(scale_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ready2) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2 && ready2) begin
			prod_s3    <= mul;
			row_end_s3 <= row_end_s2;
		end
	end

	// Saturating row accumulate.
	assign row_sum  = (ROW_W+1)'(row_q) + (ROW_W+1)'(prod_s3);
	assign row_ovf  = row_sum[ROW_W] != row_sum[ROW_W-1];
	assign row_next = !row_ovf ? row_sum[ROW_W-1:0] :
	                  (row_sum[ROW_W] ? ROW_MIN : ROW_MAX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= '0;
			clip_q <= 1'b0;
		end else if (adv3) begin
			if (row_end_s3) begin
				row_q  <= '0;
				clip_q <= 1'b0;
			end else begin
				row_q  <= row_next;
				clip_q <= clip_q || row_ovf;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv3 && row_end_s3) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv3 && row_end_s3) begin
			row_value_q <= row_next;
			saturated_q <= clip_q || row_ovf;
		end
	end

	assign out_valid = out_valid_q;
	assign row_value = row_value_q;
	assign saturated = saturated_q;

	// A row result that is not taken stays presented with the same value.
	a_out_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(row_value) && $stable(saturated))
		else $error("row result changed or dropped while waiting");

	// A closing request leaves the block total empty.
	a_block_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		adv1 && close_s1 |=> block_q == '0)
		else $error("block total not cleared after block close");

	// Emitting a row leaves the row total and its clip flag clear.
	a_row_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		adv3 && row_end_s3 |=> (row_q == '0) && !clip_q && out_valid)
		else $error("row state not cleared after row result");

endmodule
